/* hdl/two_stacks_shared_memory_assert.svh */
// Assertion macros for the two-stack block.
`ifndef TWO_STACKS_SHARED_MEMORY_ASSERT_SVH
`define TWO_STACKS_SHARED_MEMORY_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define TSSM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
`define TSSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define TSSM_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define TSSM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* hdl/tssm_pkg.sv */
package tssm_pkg;

   // DEPTH must be a power of two; upper stack addresses wrap modulo DEPTH.
   localparam int DEPTH   = 256;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int COUNT_W = ADDR_W + 1;
   localparam int SUM_W   = COUNT_W + 1;
   localparam int CAP_W   = 9;
   localparam int WORD_W  = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

   typedef enum logic [0:0] {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } opcode_type;

   typedef enum logic [0:0] {
      STACK_LOWER = 1'b0,
      STACK_UPPER = 1'b1
   } stack_type;

   typedef struct packed {
      logic               opcode;
      logic               stack_select;
      logic signed [31:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pop_value;
      logic               underflow;
      logic               push_dropped;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_EXEC = 2'd1,
      ST_RESP = 2'd2
   } state_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } cmd_type;

endpackage

/* hdl/two_stacks_shared_memory.sv */
// An accepted request passes through the execute and response states; its result is held
// while the result side stalls.
// Requests are not overlapped: the single-port store is touched in the execute step
// and the controller holds one request at a time until its result is taken.
// Reset (synchronous, active high) empties both stacks and sets capacity to 256;
// store contents are not cleared.
`include "two_stacks_shared_memory_assert.svh"

module two_stacks_shared_memory (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  tssm_pkg::req_type            req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output tssm_pkg::rsp_type            rsp_payload,
   input  logic                         csr_write_enable,
   input  logic [tssm_pkg::CAP_W-1:0]   csr_write_data
);

   tssm_pkg::cmd_type cmd;

   tssm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   tssm_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_payload      (req_payload),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   `TSSM_ASSERT_NEXT(a_capture_then_execute, clock, reset, cmd.capture, cmd.execute && !rsp_valid)
   `TSSM_ASSERT_NEXT(a_execute_then_result, clock, reset, cmd.execute, rsp_valid)
   `TSSM_ASSERT_IMPLY(a_one_request_in_flight, clock, reset, rsp_valid || cmd.execute, req_stall)
   `TSSM_ASSERT_IMPLY(a_flags_exclusive, clock, reset, rsp_valid, !(rsp_payload.underflow && rsp_payload.push_dropped))

endmodule

/* hdl/tssm_ctrl.sv */
module tssm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tssm_pkg::cmd_type cmd
);

   tssm_pkg::state_type state_ff;
   tssm_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tssm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tssm_pkg::ST_IDLE: begin
            if (req_valid) state_in = tssm_pkg::ST_EXEC;
         end
         tssm_pkg::ST_EXEC: begin
            state_in = tssm_pkg::ST_RESP;
         end
         tssm_pkg::ST_RESP: begin
            if (!rsp_stall) state_in = tssm_pkg::ST_IDLE;
         end
         default: begin
            state_in = tssm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall   = 1'b1;
      rsp_valid   = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      case (state_ff)
         tssm_pkg::ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         tssm_pkg::ST_EXEC: begin
            cmd.execute = 1'b1;
         end
         tssm_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

/* hdl/tssm_dp.sv */
module tssm_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  tssm_pkg::cmd_type            cmd,
   input  tssm_pkg::req_type            req_payload,
   output tssm_pkg::rsp_type            rsp_payload,
   input  logic                         csr_write_enable,
   input  logic [tssm_pkg::CAP_W-1:0]   csr_write_data
);

   localparam int AW = tssm_pkg::ADDR_W;
   localparam int CW = tssm_pkg::COUNT_W;
   localparam int SW = tssm_pkg::SUM_W;
   localparam int WW = tssm_pkg::WORD_W;

   logic [WW-1:0]               mem [tssm_pkg::DEPTH];
   logic [WW-1:0]               rd_data_ff;

   tssm_pkg::req_type           req_ff;
   logic [tssm_pkg::CAP_W-1:0]  cap_ff;
   logic [CW-1:0]               lower_count_ff, lower_count_in;
   logic [CW-1:0]               upper_count_ff, upper_count_in;
   logic                        underflow_ff, underflow_in;
   logic                        dropped_ff, dropped_in;
   logic                        use_mem_ff, use_mem_in;

   logic [SW-1:0]               eff_cap;
   logic [SW-1:0]               used;
   logic                        is_push;
   logic                        is_upper;
   logic [CW-1:0]               sel_count;
   logic [CW-1:0]               index;
   logic [AW-1:0]               mem_addr;
   logic                        mem_we;
   logic                        mem_re;

   assign eff_cap  = (32'(cap_ff) > 32'(tssm_pkg::DEPTH)) ? SW'(tssm_pkg::DEPTH)
                                                            : SW'(cap_ff);
   assign used     = SW'(lower_count_ff) + SW'(upper_count_ff);
   assign is_push  = (req_ff.opcode == tssm_pkg::OP_PUSH);
   assign is_upper = (req_ff.stack_select == tssm_pkg::STACK_UPPER);
   assign sel_count = is_upper ? upper_count_ff : lower_count_ff;

   // push writes at the current count, pop reads at count - 1
   assign index = is_push ? sel_count : sel_count - CW'(1);

   // upper stack entry k sits at (min(cap, DEPTH) - 1 - k) mod DEPTH
   assign mem_addr = is_upper ? (eff_cap[AW-1:0] - AW'(1) - index[AW-1:0])
                              : index[AW-1:0];

   always_comb begin
      lower_count_in = lower_count_ff;
      upper_count_in = upper_count_ff;
      underflow_in   = underflow_ff;
      dropped_in     = dropped_ff;
      use_mem_in     = use_mem_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      if (cmd.execute) begin
         underflow_in = 1'b0;
         dropped_in   = 1'b0;
         use_mem_in   = 1'b0;
         if (is_push) begin
            if (used < eff_cap) begin
               mem_we = 1'b1;
               if (is_upper) upper_count_in = upper_count_ff + CW'(1);
               else          lower_count_in = lower_count_ff + CW'(1);
            end else begin
               dropped_in = 1'b1;
            end
         end else begin
            if (sel_count == '0) begin
               underflow_in = 1'b1;
            end else begin
               mem_re     = 1'b1;
               use_mem_in = 1'b1;
               if (is_upper) upper_count_in = upper_count_ff - CW'(1);
               else          lower_count_in = lower_count_ff - CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff         <= tssm_pkg::CAP_RESET;
         lower_count_ff <= '0;
         upper_count_ff <= '0;
         underflow_ff   <= 1'b0;
         dropped_ff     <= 1'b0;
         use_mem_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) cap_ff <= csr_write_data;
         lower_count_ff <= lower_count_in;
         upper_count_ff <= upper_count_in;
         underflow_ff   <= underflow_in;
         dropped_ff     <= dropped_in;
         use_mem_ff     <= use_mem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_payload;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= req_ff.push_value;
      if (mem_re) rd_data_ff <= mem[mem_addr];
   end

   always_comb begin
      rsp_payload.underflow    = underflow_ff;
      rsp_payload.push_dropped = dropped_ff;
      if (underflow_ff)    rsp_payload.pop_value = '1;
      else if (use_mem_ff) rsp_payload.pop_value = rd_data_ff;
      else                 rsp_payload.pop_value = '0;
   end

endmodule

/* tb/two_stacks_shared_memory_test.sv */
// Predicts the two stacks and checks each popped word and flag in order.
class stack_scoreboard;
   logic [tssm_pkg::WORD_W-1:0] store [tssm_pkg::DEPTH];
   bit                          written [tssm_pkg::DEPTH];
   int unsigned                 lower_count;
   int unsigned                 upper_count;
   int unsigned                 capacity;
   tssm_pkg::rsp_type           expected_q [$];
   int unsigned                 error_count;

   function new();
      foreach (written[i]) begin
         written[i] = 1'b0;
         store[i] = '0;
      end
      lower_count = 0;
      upper_count = 0;
      capacity = 32'(tssm_pkg::CAP_RESET);
      error_count = 0;
   endfunction

   function int unsigned usable();
      return (capacity > tssm_pkg::DEPTH) ? tssm_pkg::DEPTH : capacity;
   endfunction

   // upper stack entry k counted from its bottom, relative to the current capacity
   function int unsigned upper_slot(int unsigned k);
      return (usable() + tssm_pkg::DEPTH - 1 - k) % tssm_pkg::DEPTH;
   endfunction

   function int unsigned depth_of(logic sel);
      return (sel == tssm_pkg::STACK_LOWER) ? lower_count : upper_count;
   endfunction

   function int unsigned top_slot(logic sel);
      return (sel == tssm_pkg::STACK_LOWER) ? (lower_count - 1) % tssm_pkg::DEPTH
                                            : upper_slot(upper_count - 1);
   endfunction

   // a pop must never land on an entry that was never pushed
   function bit pop_is_safe(logic sel);
      if (depth_of(sel) == 0)
         return 1'b1;
      return written[top_slot(sel)];
   endfunction

   function int unsigned outstanding();
      return expected_q.size();
   endfunction

   function void note_request(tssm_pkg::req_type r);
      tssm_pkg::rsp_type e;
      int unsigned       slot;
      e = '0;
      if (r.opcode == tssm_pkg::OP_PUSH) begin
         if (lower_count + upper_count < usable()) begin
            if (r.stack_select == tssm_pkg::STACK_LOWER) begin
               slot = lower_count % tssm_pkg::DEPTH;
               lower_count++;
            end else begin
               slot = upper_slot(upper_count);
               upper_count++;
            end
            store[slot] = r.push_value;
            written[slot] = 1'b1;
         end else begin
            e.push_dropped = 1'b1;
         end
      end else if (depth_of(r.stack_select) == 0) begin
         e.pop_value = -1;
         e.underflow = 1'b1;
      end else begin
         slot = top_slot(r.stack_select);
         if (r.stack_select == tssm_pkg::STACK_LOWER)
            lower_count--;
         else
            upper_count--;
         e.pop_value = store[slot];
      end
      expected_q.push_back(e);
   endfunction

   function void check_response(tssm_pkg::rsp_type got);
      tssm_pkg::rsp_type e;
      if (expected_q.size() == 0) begin
         $display("%0t: unexpected response %h", $time, got);
         error_count++;
         return;
      end
      e = expected_q.pop_front();
      if (got.pop_value !== e.pop_value) begin
         $display("%0t: pop_value expected %h got %h", $time, e.pop_value, got.pop_value);
         error_count++;
      end
      if (got.underflow !== e.underflow) begin
         $display("%0t: underflow expected %b got %b", $time, e.underflow, got.underflow);
         error_count++;
      end
      if (got.push_dropped !== e.push_dropped) begin
         $display("%0t: push_dropped expected %b got %b", $time, e.push_dropped,
                  got.push_dropped);
         error_count++;
      end
   endfunction
endclass

module two_stacks_shared_memory_test;

   localparam int HOLD_OFF_CYCLES = 200;
   localparam int TIMEOUT_CYCLES  = 200000;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   tssm_pkg::req_type          req_payload = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   tssm_pkg::rsp_type          rsp_payload;
   logic                       csr_write_enable = 1'b0;
   logic [tssm_pkg::CAP_W-1:0] csr_write_data = '0;

   bit                         gaps_on = 1'b1;
   bit                         hold_off_request = 1'b0;
   stack_scoreboard            sb;

   two_stacks_shared_memory u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall)
         sb.check_response(rsp_payload);
   end

   // result side: random stalls, plus one long hold-off on demand
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_request = 1'b0;
         end else begin
            rsp_stall <= gaps_on && ($urandom_range(99) < 31);
         end
      end
   end

   initial begin
      #(12 * TIMEOUT_CYCLES);
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic tssm_pkg::req_type make_req(tssm_pkg::opcode_type op,
                                                  tssm_pkg::stack_type sel,
                                                  logic signed [tssm_pkg::WORD_W-1:0] value);
      tssm_pkg::req_type r;
      r.opcode = op;
      r.stack_select = sel;
      r.push_value = value;
      return r;
   endfunction

   function automatic tssm_pkg::req_type random_request(int push_pct);
      tssm_pkg::req_type r;
      r.opcode = ($urandom_range(99) < push_pct) ? tssm_pkg::OP_PUSH : tssm_pkg::OP_POP;
      r.stack_select = 1'($urandom_range(1));
      case ($urandom_range(7))
         0: r.push_value = 32'h7FFF_FFFF;
         1: r.push_value = 32'h8000_0000;
         2: r.push_value = 32'hFFFF_FFFF;
         3: r.push_value = '0;
         default: r.push_value = $urandom;
      endcase
      // after a capacity change the upper top may sit on a stale address
      if (r.opcode == tssm_pkg::OP_POP && !sb.pop_is_safe(r.stack_select))
         r.opcode = tssm_pkg::OP_PUSH;
      return r;
   endfunction

   task automatic send_request(input tssm_pkg::req_type r);
      while (gaps_on && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   task automatic write_capacity(input logic [tssm_pkg::CAP_W-1:0] value);
      csr_write_data <= value;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.capacity = 32'(value);
   endtask

   task automatic run_phase(input logic [tssm_pkg::CAP_W-1:0] cap, input int count,
                            input int push_pct, input bit hold);
      wait_for_results();
      write_capacity(cap);
      hold_off_request = hold;
      for (int i = 0; i < count; i++) begin
         if (i == count / 2)
            wait_for_results();
         send_request(random_request(push_pct));
      end
   endtask

   initial begin
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_capacity(9'd4);
      send_request(make_req(tssm_pkg::OP_POP, tssm_pkg::STACK_LOWER, 32'sd0));
      send_request(make_req(tssm_pkg::OP_POP, tssm_pkg::STACK_UPPER, 32'sd0));
      send_request(make_req(tssm_pkg::OP_PUSH, tssm_pkg::STACK_LOWER, 32'h7FFF_FFFF));
      send_request(make_req(tssm_pkg::OP_PUSH, tssm_pkg::STACK_UPPER, 32'h8000_0000));
      send_request(make_req(tssm_pkg::OP_PUSH, tssm_pkg::STACK_LOWER, 32'h0000_0000));
      send_request(make_req(tssm_pkg::OP_PUSH, tssm_pkg::STACK_UPPER, 32'hFFFF_FFFF));
      // both stacks together at capacity
      send_request(make_req(tssm_pkg::OP_PUSH, tssm_pkg::STACK_LOWER, 32'sd5));
      send_request(make_req(tssm_pkg::OP_PUSH, tssm_pkg::STACK_UPPER, 32'sd6));
      send_request(make_req(tssm_pkg::OP_POP, tssm_pkg::STACK_UPPER, 32'sd0));
      send_request(make_req(tssm_pkg::OP_POP, tssm_pkg::STACK_LOWER, 32'sd0));
      send_request(make_req(tssm_pkg::OP_POP, tssm_pkg::STACK_UPPER, 32'sd0));
      send_request(make_req(tssm_pkg::OP_POP, tssm_pkg::STACK_LOWER, 32'sd0));
      send_request(make_req(tssm_pkg::OP_POP, tssm_pkg::STACK_LOWER, 32'sd0));
      send_request(make_req(tssm_pkg::OP_PUSH, tssm_pkg::STACK_LOWER, 32'sd11));
      send_request(make_req(tssm_pkg::OP_PUSH, tssm_pkg::STACK_UPPER, 32'sd22));

      // shrink while occupied: upper entries are addressed from the new top
      wait_for_results();
      write_capacity(9'd2);
      send_request(make_req(tssm_pkg::OP_PUSH, tssm_pkg::STACK_LOWER, 32'sd33));
      send_request(make_req(tssm_pkg::OP_POP, tssm_pkg::STACK_UPPER, 32'sd0));
      send_request(make_req(tssm_pkg::OP_POP, tssm_pkg::STACK_LOWER, 32'sd0));

      wait_for_results();
      write_capacity(9'd0);
      send_request(make_req(tssm_pkg::OP_PUSH, tssm_pkg::STACK_LOWER, 32'sd44));
      send_request(make_req(tssm_pkg::OP_POP, tssm_pkg::STACK_LOWER, 32'sd0));

      // above DEPTH saturates
      wait_for_results();
      write_capacity(9'd511);
      send_request(make_req(tssm_pkg::OP_PUSH, tssm_pkg::STACK_UPPER, 32'sd55));
      send_request(make_req(tssm_pkg::OP_POP, tssm_pkg::STACK_UPPER, 32'sd0));

      run_phase(9'd256, 100, 55, 1'b0);
      run_phase(9'd1, 60, 50, 1'b0);
      run_phase(9'd7, 90, 70, 1'b1);
      run_phase(9'd300, 80, 60, 1'b0);
      gaps_on = 1'b0;
      run_phase(9'd16, 100, 75, 1'b0);
      gaps_on = 1'b1;
      run_phase(9'd0, 30, 50, 1'b0);
      run_phase(9'd3, 80, 50, 1'b0);
      run_phase(9'd511, 80, 40, 1'b0);
      run_phase(9'd128, 100, 80, 1'b0);
      run_phase(9'd256, 80, 30, 1'b0);

      wait_for_results();
      repeat (10) @(posedge clock);
      if (sb.error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* files.f */
+incdir+hdl
hdl/tssm_pkg.sv
hdl/tssm_ctrl.sv
hdl/tssm_dp.sv
hdl/two_stacks_shared_memory.sv
tb/two_stacks_shared_memory_test.sv
